// ----- design/gtp_pkg.sv -----
package gtp_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_COLS    = 5;

  typedef enum logic [1:0] {
    FUNC_LETTER = 2'd0,
    FUNC_SPACER = 2'd1,
    FUNC_SYMBOL = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef logic [4:0] glyph_idx_t;

  localparam glyph_idx_t GLYPH_BLANK = 5'd29;
  localparam glyph_idx_t GLYPH_SMILE = 5'd30;

  localparam logic REG_SMILE = 1'b0;

  // letter table order: A B D E F G H I M N O S T V X Y 1-9 0 space . :
  function automatic glyph_idx_t letter_index(logic [7:0] code);
    glyph_idx_t idx;
    case (code)
      "A": idx = 5'd0;
      "B": idx = 5'd1;
      "D": idx = 5'd2;
      "E": idx = 5'd3;
      "F": idx = 5'd4;
      "G": idx = 5'd5;
      "H": idx = 5'd6;
      "I": idx = 5'd7;
      "M": idx = 5'd8;
      "N": idx = 5'd9;
      "O": idx = 5'd10;
      "S": idx = 5'd11;
      "T": idx = 5'd12;
      "V": idx = 5'd13;
      "X": idx = 5'd14;
      "Y": idx = 5'd15;
      "1": idx = 5'd16;
      "2": idx = 5'd17;
      "3": idx = 5'd18;
      "4": idx = 5'd19;
      "5": idx = 5'd20;
      "6": idx = 5'd21;
      "7": idx = 5'd22;
      "8": idx = 5'd23;
      "9": idx = 5'd24;
      "0": idx = 5'd25;
      " ": idx = 5'd26;
      ".": idx = 5'd27;
      ":": idx = 5'd28;
      default: idx = GLYPH_BLANK;
    endcase
    return idx;
  endfunction

  function automatic logic [2:0] glyph_width(glyph_idx_t idx);
    logic [2:0] w;
    case (idx)
      5'd7, 5'd16:                w = 3'd3;
      5'd26, GLYPH_BLANK:         w = 3'd2;
      5'd27, 5'd28:               w = 3'd1;
      5'd31:                      w = 3'd2;
      default:                    w = 3'd5;
    endcase
    return w;
  endfunction

  // seven rows, top row in the highest bits, leftmost column is row bit (width - 1)
  function automatic logic [34:0] glyph_bits(glyph_idx_t idx);
    logic [34:0] b;
    case (idx)
      5'd0:  b = {5'h0F, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      5'd1:  b = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      5'd2:  b = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      5'd3:  b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      5'd4:  b = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      5'd5:  b = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0E};
      5'd6:  b = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      5'd7:  b = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h07};
      5'd8:  b = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      5'd9:  b = {5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      5'd10: b = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      5'd11: b = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
      5'd12: b = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      5'd13: b = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      5'd14: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      5'd15: b = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      5'd16: b = {5'h02, 5'h06, 5'h02, 5'h02, 5'h02, 5'h02, 5'h07};
      5'd17: b = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
      5'd18: b = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
      5'd19: b = {5'h03, 5'h05, 5'h09, 5'h11, 5'h1F, 5'h01, 5'h01};
      5'd20: b = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      5'd21: b = {5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      5'd22: b = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      5'd23: b = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      5'd24: b = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
      5'd25: b = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      5'd27: b = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01};
      5'd28: b = {5'h00, 5'h00, 5'h01, 5'h00, 5'h00, 5'h01, 5'h00};
      GLYPH_SMILE: b = {5'h02, 5'h01, 5'h09, 5'h01, 5'h01, 5'h09, 5'h02};
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic glyph_cell(logic [34:0] b, logic [2:0] w, int row, int c);
    logic [4:0] r;
    logic       v;
    r = b[34 - 5 * row -: 5];
    v = 1'b0;
    if (c < int'(w)) begin
      v = r[int'(w) - 1 - c];
    end
    return v;
  endfunction

  // [6:0]: column cells bottom-up, [7]: some later column has a set cell
  function automatic logic [7:0] glyph_col(glyph_idx_t idx, logic [2:0] col);
    logic [34:0] b;
    logic [2:0]  w;
    logic [7:0]  res;
    b   = glyph_bits(idx);
    w   = glyph_width(idx);
    res = '0;
    for (int j = 0; j < GLYPH_ROWS; j++) begin
      res[j] = glyph_cell(b, w, GLYPH_ROWS - 1 - j, int'(col));
      for (int c = 0; c < GLYPH_COLS; c++) begin
        if (c > int'(col)) begin
          res[7] = res[7] | glyph_cell(b, w, j, c);
        end
      end
    end
    return res;
  endfunction

endpackage

// ----- design/glyph_to_pixel_writer.sv -----
// A beat is registered when the walker reaches a written cell; in letter and spacer modes the
// first beat comes from the first cell, which the walker enters once the item is accepted.
// One glyph cell per cycle while the sink does not stall, set by the column-by-column walk
// through the glyph ROM; an item is walked to its end before the next one is taken.
// The next item is taken the cycle after the walk ends; func 3 is dropped at once.
// Reset returns the walker to idle, clears the output valid and sets smile_code to 0.
module glyph_to_pixel_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // glyph_code, origin_x, origin_y, fg r/g/b, bg r/g/b, pad
  input  logic [1:0]  s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // column_start, page_start, pixel_color, advance_width, pad
  output logic        m_tlast,  // last_pixel
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gtp_pkg::state_t     state, state_next;
  gtp_pkg::glyph_idx_t glyph, glyph_next, glyph_sel;
  logic [2:0]  col, col_next, row, row_next;
  logic [7:0]  rom_q;
  logic        opaque;
  logic [15:0] base_col, base_page, fg, bg;
  logic [7:0]  smile_code;
  logic [2:0]  width;
  logic        out_free, pix_set, emit, last_row, last_col, last;
  logic        accept;

  logic [1:0]  func;
  logic [7:0]  glyph_code;
  logic [9:0]  origin_x, origin_y;
  logic [7:0]  fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue;

  assign func       = s_tuser;
  assign glyph_code = s_tdata[7:0];
  assign origin_x   = s_tdata[17:8];
  assign origin_y   = s_tdata[27:18];
  assign fg_red     = s_tdata[35:28];
  assign fg_green   = s_tdata[43:36];
  assign fg_blue    = s_tdata[51:44];
  assign bg_red     = s_tdata[59:52];
  assign bg_green   = s_tdata[67:60];
  assign bg_blue    = s_tdata[75:68];

  assign pready = 1'b1;
  assign prdata = (paddr[2] == gtp_pkg::REG_SMILE) ? {24'd0, smile_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      smile_code <= 8'd0;
    end else if (psel && penable && pwrite && paddr[2] == gtp_pkg::REG_SMILE) begin
      smile_code <= pwdata[7:0];
    end
  end

  always_comb begin
    case (gtp_pkg::func_t'(func))
      gtp_pkg::FUNC_LETTER: glyph_sel = gtp_pkg::letter_index(glyph_code);
      gtp_pkg::FUNC_SYMBOL: glyph_sel = (glyph_code == smile_code) ? gtp_pkg::GLYPH_SMILE
                                                                    : gtp_pkg::GLYPH_BLANK;
      default:              glyph_sel = gtp_pkg::GLYPH_BLANK;
    endcase
  end

  assign width    = gtp_pkg::glyph_width(glyph);
  assign out_free = !m_tvalid || m_tready;
  assign pix_set  = rom_q[row];
  assign emit     = opaque || pix_set;
  assign last_row = (row == 3'(gtp_pkg::GLYPH_ROWS - 1));
  assign last_col = (col == width - 3'd1);
  assign last     = opaque ? (last_row && last_col)
                           : ((((rom_q[6:0] >> row) >> 1) == 7'd0) && !rom_q[7]);

  always_comb begin
    state_next = state;
    glyph_next = glyph;
    col_next   = col;
    row_next   = row;
    s_tready   = 1'b0;
    accept     = 1'b0;
    case (state)
      gtp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          accept = 1'b1;
          if (gtp_pkg::func_t'(func) != gtp_pkg::FUNC_NONE) begin
            state_next = gtp_pkg::ST_RUN;
            glyph_next = glyph_sel;
            col_next   = 3'd0;
            row_next   = 3'd0;
          end
        end
      end
      gtp_pkg::ST_RUN: begin
        if (out_free) begin
          if (last_row) begin
            row_next = 3'd0;
            if (last_col) begin
              state_next = gtp_pkg::ST_IDLE;
            end else begin
              col_next = col + 3'd1;
            end
          end else begin
            row_next = row + 3'd1;
          end
        end
      end
      default: state_next = gtp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gtp_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gtp_pkg::ST_RUN && out_free && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // glyph ROM, registered read at the column the walker holds next cycle
  always_ff @(posedge clk) begin
    rom_q <= gtp_pkg::glyph_col(glyph_next, col_next);
  end

  always_ff @(posedge clk) begin
    glyph <= glyph_next;
    col   <= col_next;
    row   <= row_next;
    if (accept) begin
      opaque    <= (gtp_pkg::func_t'(func) != gtp_pkg::FUNC_SYMBOL);
      base_col  <= 16'(gtp_pkg::SCREEN_HEIGHT - 1) - {6'd0, origin_y};
      base_page <= 16'(gtp_pkg::SCREEN_WIDTH - 1) - {6'd0, origin_x};
      fg        <= {fg_red[7:3], fg_green[7:3], 1'b0, fg_blue[7:3]};
      bg        <= {bg_red[7:3], bg_green[7:3], 1'b0, bg_blue[7:3]};
    end
    if (state == gtp_pkg::ST_RUN && out_free && emit) begin
      m_tdata <= {5'd0, width, (pix_set ? fg : bg),
                  base_page - {13'd0, col}, base_col - {13'd0, row}};
      m_tlast <= last;
    end
  end

endmodule
